// ----- src/s5cr_pkg.sv -----
// ----------------------------------------------------------------------------
// s5cr_pkg: shared types and constants of the SOCKS5 CONNECT request parser
// Holds the request field codes, the verdict status codes and the result type.
// ----------------------------------------------------------------------------
package s5cr_pkg;

  localparam logic [7:0] SOCKS_VERSION = 8'h05;
  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN   = 8'h03;

  // Fixed request layout: header, four address bytes and two port bytes.
  localparam logic [8:0] IPV4_REQUEST_BYTES = 9'd10;
  localparam logic [8:0] IPV4_LAST_INDEX    = IPV4_REQUEST_BYTES - 9'd1;
  localparam logic [8:0] HOST_CAPACITY_RESET = 9'd256;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NEED_MORE     = 3'd1,
    ST_MALFORMED     = 3'd2,
    ST_BAD_COMMAND   = 3'd3,
    ST_BAD_ADDR_TYPE = 3'd4
  } status_t;

  typedef struct packed {
    logic        is_final;
    logic [7:0]  host_byte;
    status_t     status;
    logic        address_kind;
    logic [31:0] ipv4_address;
    logic [15:0] port;
    logic [7:0]  domain_length;
    logic [8:0]  consumed;
  } result_t;

endpackage

// ----- src/s5cr_req_if.sv -----
// ----------------------------------------------------------------------------
// s5cr_req_if: request byte channel
// Carries one raw request byte per item with its end-of-buffer mark.
// ----------------------------------------------------------------------------
interface s5cr_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// ----- src/s5cr_res_if.sv -----
// ----------------------------------------------------------------------------
// s5cr_res_if: parser result channel
// Carries host-byte items and final verdict items of the request parser.
// ----------------------------------------------------------------------------
interface s5cr_res_if;
  logic        valid;
  logic        ready;
  logic        is_final;
  logic [7:0]  host_byte;
  logic [2:0]  status;
  logic        address_kind;
  logic [31:0] ipv4_address;
  logic [15:0] port;
  logic [7:0]  domain_length;
  logic [8:0]  consumed;

  modport source (
    output valid, output is_final, output host_byte, output status,
    output address_kind, output ipv4_address, output port,
    output domain_length, output consumed, input ready
  );
  modport sink (
    input valid, input is_final, input host_byte, input status,
    input address_kind, input ipv4_address, input port,
    input domain_length, input consumed, output ready
  );
endinterface

// ----- src/socks5_connect_request_parser_top.sv -----
// ----------------------------------------------------------------------------
// socks5_connect_request_parser_top: SOCKS5 CONNECT request parser
// Parses request bytes one at a time, streams domain characters and closes
// each request with a verdict item.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Modport  Contents
//  req       in   sink     data_byte, end_of_buffer
//  res       out  source   is_final, host_byte, status, address_kind,
//                          ipv4_address, port, domain_length, consumed
//  cfg       in   -        cfg_write, cfg_data (host_capacity, 9 bits)
//
// Every byte is decoded in the cycle it is accepted, and its result item, if
// it has one, is registered in the result register, or in the skid register
// while res stalls. One byte can be accepted in every cycle while req is
// ready. A two-entry output stage (result register plus skid register) keeps
// req ready while one result waits on a stalled res; req drops ready only
// while both entries are full. Reset (rst, synchronous, active high) clears
// the parse state, empties the output stage and sets host_capacity to 256.
//
module socks5_connect_request_parser_top
  import s5cr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  s5cr_req_if.sink   req,
  s5cr_res_if.source res,
  input  logic       cfg_write,
  input  logic [8:0] cfg_data
);

  // Configuration register.
  logic [8:0] host_capacity;

  // Parse state of the current request.
  logic [8:0]  byte_index;
  logic [7:0]  saved_version;
  logic [7:0]  saved_command;
  logic        kind_reg;
  logic [7:0]  length_reg;
  logic [31:0] address_acc;
  logic [15:0] port_acc;
  logic        verdict_given;

  logic [8:0]  byte_index_next;
  logic [7:0]  saved_version_next;
  logic [7:0]  saved_command_next;
  logic        kind_reg_next;
  logic [7:0]  length_reg_next;
  logic [31:0] address_acc_next;
  logic [15:0] port_acc_next;
  logic        verdict_given_next;

  // Output stage: result register and skid register.
  result_t out_item;
  logic    out_valid;
  result_t skid_item;
  logic    skid_valid;

  logic    accept;
  logic    push;
  logic    pop;
  result_t new_item;

  // Decode of the current byte.
  logic       fin;
  logic       host;
  result_t    fin_item;
  logic [8:0] host_last_index;
  logic [8:0] domain_last_index;
  logic [15:0] port_shifted;

  assign req.ready = !skid_valid;
  assign accept    = req.valid && req.ready;
  assign pop       = out_valid && res.ready;

  assign host_last_index   = {1'b0, length_reg} + 9'd4;
  assign domain_last_index = {1'b0, length_reg} + 9'd6;
  assign port_shifted      = {port_acc[7:0], req.data_byte};

  always_comb begin
    saved_version_next = saved_version;
    saved_command_next = saved_command;
    kind_reg_next      = kind_reg;
    length_reg_next    = length_reg;
    address_acc_next   = address_acc;
    port_acc_next      = port_acc;
    fin                = 1'b0;
    host               = 1'b0;
    fin_item           = '0;
    fin_item.is_final  = 1'b1;
    fin_item.status    = ST_OK;

    if (byte_index == 9'd0) begin
      saved_version_next = req.data_byte;
    end else if (byte_index == 9'd1) begin
      saved_command_next = req.data_byte;
    end else if (byte_index == 9'd3) begin
      // Version, then command, then address type decide the verdict.
      priority if (saved_version != SOCKS_VERSION) begin
        fin             = 1'b1;
        fin_item.status = ST_MALFORMED;
      end else if (saved_command != CMD_CONNECT) begin
        fin             = 1'b1;
        fin_item.status = ST_BAD_COMMAND;
      end else if (req.data_byte == ATYP_IPV4) begin
        kind_reg_next = 1'b0;
      end else if (req.data_byte == ATYP_DOMAIN) begin
        kind_reg_next = 1'b1;
      end else begin
        fin             = 1'b1;
        fin_item.status = ST_BAD_ADDR_TYPE;
      end
    end else if (byte_index >= 9'd4) begin
      if (!kind_reg) begin
        if (byte_index <= 9'd7) begin
          address_acc_next = {address_acc[23:0], req.data_byte};
        end else begin
          port_acc_next = port_shifted;
        end
        if (byte_index == IPV4_LAST_INDEX) begin
          fin                   = 1'b1;
          fin_item.ipv4_address = address_acc;
          fin_item.port         = port_shifted;
          fin_item.consumed     = IPV4_REQUEST_BYTES;
        end
      end else begin
        if (byte_index == 9'd4) begin
          length_reg_next = req.data_byte;
        end else if (byte_index <= host_last_index) begin
          host = 1'b1;
        end else begin
          port_acc_next = port_shifted;
        end
        // The length byte itself can never close the request.
        if (byte_index != 9'd4 && byte_index == domain_last_index) begin
          fin = 1'b1;
          if ({1'b0, length_reg} >= host_capacity) begin
            fin_item.status = ST_MALFORMED;
          end else begin
            fin_item.address_kind  = 1'b1;
            fin_item.port          = port_shifted;
            fin_item.domain_length = length_reg;
            fin_item.consumed      = {1'b0, length_reg} + 9'd7;
          end
        end
      end
    end
  end

  always_comb begin
    new_item = '0;
    push     = 1'b0;
    if (accept && !verdict_given) begin
      priority if (fin) begin
        new_item = fin_item;
        push     = 1'b1;
      end else if (req.end_of_buffer) begin
        new_item.is_final = 1'b1;
        new_item.status   = ST_NEED_MORE;
        push              = 1'b1;
      end else if (host) begin
        new_item.host_byte = req.data_byte;
        push               = 1'b1;
      end else begin
        // Header, address, length and port bytes in mid-request give no item.
        push = 1'b0;
      end
    end
  end

  always_comb begin
    byte_index_next    = byte_index;
    verdict_given_next = verdict_given;
    if (!verdict_given && byte_index != 9'd511) begin
      byte_index_next = byte_index + 9'd1;
    end
    if (!verdict_given && fin) begin
      verdict_given_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      host_capacity <= HOST_CAPACITY_RESET;
    end else if (cfg_write) begin
      host_capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      saved_version <= '0;
      saved_command <= '0;
      kind_reg      <= 1'b0;
      length_reg    <= '0;
      address_acc   <= '0;
      port_acc      <= '0;
      verdict_given <= 1'b0;
    end else if (accept) begin
      if (req.end_of_buffer) begin
        // The end of a buffer always starts a fresh request.
        byte_index    <= '0;
        saved_version <= '0;
        saved_command <= '0;
        kind_reg      <= 1'b0;
        length_reg    <= '0;
        address_acc   <= '0;
        port_acc      <= '0;
        verdict_given <= 1'b0;
      end else if (!verdict_given) begin
        byte_index    <= byte_index_next;
        saved_version <= saved_version_next;
        saved_command <= saved_command_next;
        kind_reg      <= kind_reg_next;
        length_reg    <= length_reg_next;
        address_acc   <= address_acc_next;
        port_acc      <= port_acc_next;
        verdict_given <= verdict_given_next;
      end
    end
  end

  // Output stage. The skid register fills only when a new item arrives while
  // the result register is full and not being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_item   <= skid_item;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_item  <= new_item;
        skid_valid <= 1'b1;
      end else begin
        out_item  <= new_item;
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid         = out_valid;
  assign res.is_final      = out_item.is_final;
  assign res.host_byte     = out_item.host_byte;
  assign res.status        = out_item.status;
  assign res.address_kind  = out_item.address_kind;
  assign res.ipv4_address  = out_item.ipv4_address;
  assign res.port          = out_item.port;
  assign res.domain_length = out_item.domain_length;
  assign res.consumed      = out_item.consumed;

endmodule
